// ----- rtl/uhts_pkg.sv -----
// Shared types and codes for the USB host transfer sequencer.
package uhts_pkg;

  // input action codes
  localparam logic [1:0] ACT_OUT   = 2'd0;
  localparam logic [1:0] ACT_SETUP = 2'd1;
  localparam logic [1:0] ACT_IN    = 2'd2;
  localparam logic [1:0] ACT_HS    = 2'd3;

  // device handshake codes (anything else counts as NAK)
  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  // packet tokens
  localparam logic [1:0] TOK_OUT   = 2'd0;
  localparam logic [1:0] TOK_SETUP = 2'd1;
  localparam logic [1:0] TOK_IN    = 2'd2;

  // result kinds
  localparam logic RK_PACKET = 1'b0;
  localparam logic RK_FINISH = 1'b1;

  // finish status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NAK   = 2'd1;
  localparam logic [1:0] ST_STALL = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DEV_ADDR  = 3'd0;
  localparam logic [2:0] REG_ENDPOINT  = 3'd1;
  localparam logic [2:0] REG_MAX_PKT   = 3'd2;
  localparam logic [2:0] REG_RETRY_LIM = 3'd3;
  localparam logic [2:0] REG_PREAMBLE  = 3'd4;

  localparam logic [6:0] MPS_MAX = 7'd64;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_IN   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_STALL    = 3'd2,
    EV_NAK_FAIL = 3'd3,
    EV_RETRY    = 3'd4,
    EV_DONE     = 3'd5,
    EV_NEXT     = 3'd6
  } seq_event_t;

endpackage

// ----- rtl/usb_host_transfer_sequencer_unit.sv -----
// USB host transfer sequencer: splits transfers into packets, tracks toggles and retries.
//
//  channel   dir  handshake                 payload
//  item      in   item_valid / item_ready   action, transfer_size, handshake, residual_count
//  result    out  result_valid/result_ready result_kind, packet_pid, packet_length,
//                                           buffer_address, data_offset, data_toggle,
//                                           preamble, status, byte_count
//  config    in   APB psel/penable/pready   paddr[4:0], pwdata, prdata (5 registers)
//
// Each item is held in the input register, then moves on to the result
// register. The sequencing state is updated in the same cycle the result register
// loads, so one item per cycle is sustained while the result side keeps taking results.
// The input register moves forward whenever the result register is empty or
// being taken; a stalled result holds its item in the input register only.
// Synchronous reset clears all control state and restores register defaults.
module usb_host_transfer_sequencer_unit #(
  parameter logic [7:0] BUFFER_BASE = 8'd16,
  parameter logic [7:0] BUFFER_END  = 8'd255
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [11:0] transfer_size,
  input  logic [1:0]  handshake,
  input  logic [6:0]  residual_count,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [1:0]  packet_pid,
  output logic [6:0]  packet_length,
  output logic [7:0]  buffer_address,
  output logic [11:0] data_offset,
  output logic        data_toggle,
  output logic        preamble,
  output logic [1:0]  status,
  output logic [11:0] byte_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] device_address;
  logic [3:0] endpoint_number;
  logic [6:0] max_packet_size;
  logic [7:0] retry_limit;
  logic       preamble_enable;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= '0;
      endpoint_number <= '0;
      max_packet_size <= 7'd8;
      retry_limit     <= 8'd3;
      preamble_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        uhts_pkg::REG_DEV_ADDR:  device_address  <= pwdata[6:0];
        uhts_pkg::REG_ENDPOINT:  endpoint_number <= pwdata[3:0];
        uhts_pkg::REG_MAX_PKT:   max_packet_size <= pwdata[6:0];
        uhts_pkg::REG_RETRY_LIM: retry_limit     <= pwdata[7:0];
        uhts_pkg::REG_PREAMBLE:  preamble_enable <= pwdata[0];
        default: ;  // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      uhts_pkg::REG_DEV_ADDR:  prdata = {25'd0, device_address};
      uhts_pkg::REG_ENDPOINT:  prdata = {28'd0, endpoint_number};
      uhts_pkg::REG_MAX_PKT:   prdata = {25'd0, max_packet_size};
      uhts_pkg::REG_RETRY_LIM: prdata = {24'd0, retry_limit};
      uhts_pkg::REG_PREAMBLE:  prdata = {31'd0, preamble_enable};
      default:                 prdata = '0;
    endcase
  end

  // clamp max packet size to 1..64, retry limit to at least 1
  logic [6:0] mps_eff;
  logic [7:0] limit_eff;

  assign mps_eff   = (max_packet_size == 7'd0) ? 7'd1 :
                     (max_packet_size > uhts_pkg::MPS_MAX) ? uhts_pkg::MPS_MAX :
                     max_packet_size;
  assign limit_eff = (retry_limit == 8'd0) ? 8'd1 : retry_limit;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [11:0] s1_size;
  logic [1:0]  s1_hs;
  logic [6:0]  s1_resid;
  logic        s1_go;

  // s1 moves on when the result register can take whatever it produces
  assign s1_go      = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_action <= action;
      s1_size   <= transfer_size;
      s1_hs     <= handshake;
      s1_resid  <= residual_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing state
  // ---------------------------------------------------------------------------
  uhts_pkg::phase_t phase, phase_next;
  logic        is_setup, is_setup_next;
  logic [11:0] total_size, total_size_next;
  logic [11:0] remaining_bytes, remaining_bytes_next;
  logic [6:0]  current_length, current_length_next;
  logic [7:0]  attempts_used, attempts_used_next;
  logic        out_toggle, out_toggle_next;
  logic        in_toggle, in_toggle_next;
  logic [7:0]  in_buffer_pointer, in_buffer_pointer_next;

  // ---------------------------------------------------------------------------
  // Datapath for the handshake cases
  // ---------------------------------------------------------------------------
  logic [6:0]  got;          // bytes the device actually returned on IN
  logic [11:0] rem_ack;      // remaining after an ACK
  logic [7:0]  ibp_ack;      // IN pointer after an ACK
  logic [6:0]  len_ack;      // next packet length after an ACK
  logic [6:0]  len_start;    // first packet length
  logic        ibp_wrap;     // next IN packet would run past the buffer end
  logic [7:0]  ibp_nxt_pkt;  // IN pointer for the next packet
  logic [1:0]  cur_pid;
  logic [1:0]  start_pid;
  logic        is_in_phase;
  uhts_pkg::seq_event_t ev;

  assign is_in_phase = (phase == uhts_pkg::PH_IN);

  assign got     = (s1_resid > current_length) ? 7'd0 : (current_length - s1_resid);
  assign rem_ack = is_in_phase ? (remaining_bytes - {5'd0, got})
                               : (remaining_bytes - {5'd0, current_length});
  assign ibp_ack = in_buffer_pointer + {1'b0, got};
  assign len_ack = (rem_ack > {5'd0, mps_eff}) ? mps_eff : rem_ack[6:0];
  assign len_start = (s1_size > {5'd0, mps_eff}) ? mps_eff : s1_size[6:0];
  assign ibp_wrap  = ({1'b0, ibp_ack} + {2'd0, len_ack}) > {1'b0, BUFFER_END};
  assign ibp_nxt_pkt = ibp_wrap ? BUFFER_BASE : ibp_ack;

  assign cur_pid = is_in_phase ? uhts_pkg::TOK_IN :
                   (is_setup ? uhts_pkg::TOK_SETUP : uhts_pkg::TOK_OUT);

  always_comb begin
    case (s1_action)
      uhts_pkg::ACT_IN:    start_pid = uhts_pkg::TOK_IN;
      uhts_pkg::ACT_SETUP: start_pid = uhts_pkg::TOK_SETUP;
      default:             start_pid = uhts_pkg::TOK_OUT;
    endcase
  end

  // event decode
  always_comb begin
    ev = uhts_pkg::EV_NONE;
    if (!s1_go) begin
      ev = uhts_pkg::EV_NONE;
    end else if (s1_action != uhts_pkg::ACT_HS) begin
      ev = uhts_pkg::EV_START;            // also drops any running transfer
    end else if (phase == uhts_pkg::PH_IDLE) begin
      ev = uhts_pkg::EV_NONE;             // stray handshake
    end else if (s1_hs == uhts_pkg::HS_STALL) begin
      ev = uhts_pkg::EV_STALL;
    end else if (s1_hs != uhts_pkg::HS_ACK) begin
      ev = (attempts_used >= limit_eff) ? uhts_pkg::EV_NAK_FAIL : uhts_pkg::EV_RETRY;
    end else if (rem_ack == 12'd0 || (is_in_phase && got != current_length)) begin
      ev = uhts_pkg::EV_DONE;             // all bytes moved, or short IN packet
    end else begin
      ev = uhts_pkg::EV_NEXT;
    end
  end

  // next phase
  always_comb begin
    unique case (ev)
      uhts_pkg::EV_START:
        phase_next = (s1_action == uhts_pkg::ACT_IN) ? uhts_pkg::PH_IN : uhts_pkg::PH_OUT;
      uhts_pkg::EV_STALL, uhts_pkg::EV_NAK_FAIL, uhts_pkg::EV_DONE:
        phase_next = uhts_pkg::PH_IDLE;
      default:
        phase_next = phase;
    endcase
  end

  // datapath state and result
  logic        res_load;
  logic        res_kind;
  logic [1:0]  res_pid;
  logic [6:0]  res_len;
  logic [7:0]  res_addr;
  logic [11:0] res_off;
  logic        res_tog;
  logic [1:0]  res_status;
  logic [11:0] res_count;

  always_comb begin
    is_setup_next          = is_setup;
    total_size_next        = total_size;
    remaining_bytes_next   = remaining_bytes;
    current_length_next    = current_length;
    attempts_used_next     = attempts_used;
    out_toggle_next        = out_toggle;
    in_toggle_next         = in_toggle;
    in_buffer_pointer_next = in_buffer_pointer;

    res_load   = 1'b0;
    res_kind   = uhts_pkg::RK_PACKET;
    res_pid    = cur_pid;
    res_len    = current_length;
    res_addr   = is_in_phase ? in_buffer_pointer : BUFFER_BASE;
    res_off    = total_size - remaining_bytes;
    res_tog    = is_in_phase ? in_toggle : out_toggle;
    res_status = uhts_pkg::ST_OK;
    res_count  = '0;

    unique case (ev)
      uhts_pkg::EV_START: begin
        is_setup_next          = (s1_action == uhts_pkg::ACT_SETUP);
        total_size_next        = s1_size;
        remaining_bytes_next   = s1_size;
        current_length_next    = len_start;
        attempts_used_next     = 8'd1;
        in_buffer_pointer_next = BUFFER_BASE;  // wrap check lands on base as well
        res_load = 1'b1;
        res_pid  = start_pid;
        res_len  = len_start;
        res_addr = BUFFER_BASE;
        res_off  = '0;
        res_tog  = (s1_action == uhts_pkg::ACT_IN) ? in_toggle : out_toggle;
      end
      uhts_pkg::EV_RETRY: begin
        attempts_used_next = attempts_used + 8'd1;
        res_load = 1'b1;
      end
      uhts_pkg::EV_STALL, uhts_pkg::EV_NAK_FAIL: begin
        res_load   = 1'b1;
        res_kind   = uhts_pkg::RK_FINISH;
        res_status = (ev == uhts_pkg::EV_STALL) ? uhts_pkg::ST_STALL : uhts_pkg::ST_NAK;
      end
      uhts_pkg::EV_DONE: begin
        remaining_bytes_next = rem_ack;
        if (is_in_phase) begin
          in_toggle_next         = !in_toggle;
          in_buffer_pointer_next = ibp_ack;
        end else begin
          out_toggle_next = !out_toggle;
        end
        res_load   = 1'b1;
        res_kind   = uhts_pkg::RK_FINISH;
        res_status = uhts_pkg::ST_OK;
        res_count  = total_size - rem_ack;
      end
      uhts_pkg::EV_NEXT: begin
        remaining_bytes_next = rem_ack;
        current_length_next  = len_ack;
        attempts_used_next   = 8'd1;
        res_load = 1'b1;
        res_len  = len_ack;
        res_off  = total_size - rem_ack;
        if (is_in_phase) begin
          in_toggle_next         = !in_toggle;
          in_buffer_pointer_next = ibp_nxt_pkt;
          res_addr               = ibp_nxt_pkt;
          res_tog                = !in_toggle;
        end else begin
          out_toggle_next = !out_toggle;
          res_tog         = !out_toggle;
        end
      end
      default: ;
    endcase

    // finish results carry only pid, status and count
    if (res_kind == uhts_pkg::RK_FINISH) begin
      res_len  = '0;
      res_addr = '0;
      res_off  = '0;
      res_tog  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= uhts_pkg::PH_IDLE;
      is_setup          <= 1'b0;
      total_size        <= '0;
      remaining_bytes   <= '0;
      current_length    <= '0;
      attempts_used     <= '0;
      out_toggle        <= 1'b0;
      in_toggle         <= 1'b0;
      in_buffer_pointer <= BUFFER_BASE;
    end else begin
      phase             <= phase_next;
      is_setup          <= is_setup_next;
      total_size        <= total_size_next;
      remaining_bytes   <= remaining_bytes_next;
      current_length    <= current_length_next;
      attempts_used     <= attempts_used_next;
      out_toggle        <= out_toggle_next;
      in_toggle         <= in_toggle_next;
      in_buffer_pointer <= in_buffer_pointer_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= res_load;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_kind    <= res_kind;
      packet_pid     <= res_pid;
      packet_length  <= res_len;
      buffer_address <= res_addr;
      data_offset    <= res_off;
      data_toggle    <= res_tog;
      preamble       <= (res_kind == uhts_pkg::RK_PACKET) ? preamble_enable : 1'b0;
      status         <= res_status;
      byte_count     <= res_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_finish_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (ev == uhts_pkg::EV_STALL || ev == uhts_pkg::EV_NAK_FAIL || ev == uhts_pkg::EV_DONE)
    |=> (phase == uhts_pkg::PH_IDLE))
    else $error("transfer finished but phase not idle");

  a_active_attempts: assert property (@(posedge clk) disable iff (rst)
    (phase != uhts_pkg::PH_IDLE) |-> (attempts_used != 8'd0))
    else $error("active transfer with zero attempts");

  a_packet_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == uhts_pkg::RK_PACKET)
    |-> (packet_length <= uhts_pkg::MPS_MAX && status == uhts_pkg::ST_OK
         && byte_count == 12'd0))
    else $error("malformed packet command");

  a_finish_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == uhts_pkg::RK_FINISH)
    |-> (packet_length == 7'd0 && data_offset == 12'd0 && !data_toggle && !preamble))
    else $error("finish result carries packet fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !s1_go)
    else $error("result register overwritten while stalled");

endmodule

// ----- bench/usb_host_transfer_sequencer_unit_tb.sv -----
// Self-checking testbench for the USB host transfer sequencer unit.
module usb_host_transfer_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Buffer window handed to the block; the model of the IN pointer uses the same values.
  localparam logic [7:0] BUF_BASE = 8'd16;
  localparam logic [7:0] BUF_END  = 8'd255;

  // Handshake code with no meaning on the bus; the block must treat it as NAK.
  localparam logic [1:0] HS_ODD = 2'd3;

  // Two-stage pipeline: the drain cycles cover an ignored handshake still in flight.
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 400;
  // Overall run timeout in ns, with ample margin over the slowest correct run.
  localparam int TIMEOUT_NS      = 4_000_000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic        kind;
    logic [1:0]  pid;
    logic [6:0]  len;
    logic [7:0]  addr;
    logic [11:0] offset;
    logic        tog;
    logic        pre;
    logic [1:0]  st;
    logic [11:0] count;
  } host_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  action = '0;
  logic [11:0] transfer_size = '0;
  logic [1:0]  handshake = '0;
  logic [6:0]  residual_count = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        result_kind;
  logic [1:0]  packet_pid;
  logic [6:0]  packet_length;
  logic [7:0]  buffer_address;
  logic [11:0] data_offset;
  logic        data_toggle;
  logic        preamble;
  logic [1:0]  status;
  logic [11:0] byte_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk = ~clk;

  usb_host_transfer_sequencer_unit #(
    .BUFFER_BASE(BUF_BASE),
    .BUFFER_END (BUF_END)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .transfer_size (transfer_size),
    .handshake     (handshake),
    .residual_count(residual_count),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .packet_pid    (packet_pid),
    .packet_length (packet_length),
    .buffer_address(buffer_address),
    .data_offset   (data_offset),
    .data_toggle   (data_toggle),
    .preamble      (preamble),
    .status        (status),
    .byte_count    (byte_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Sequencer model: register copies, transfer state, and the queue of packet
  // commands / finish reports the block still owes us.
  // ---------------------------------------------------------------------------
  logic [6:0]  cfg_dev_addr = '0;
  logic [3:0]  cfg_endpoint = '0;
  logic [6:0]  cfg_mps      = 7'd8;
  logic [7:0]  cfg_retry    = 8'd3;
  logic        cfg_pre      = 1'b0;

  uhts_pkg::phase_t seq_phase = uhts_pkg::PH_IDLE;
  logic        seq_setup  = 1'b0;
  logic [11:0] xfer_total = '0;
  logic [11:0] bytes_left = '0;
  logic [6:0]  pkt_len    = '0;
  logic [7:0]  tries      = '0;
  logic        out_tog    = 1'b0;
  logic        in_tog     = 1'b0;
  logic [7:0]  in_ptr     = BUF_BASE;

  host_result_t host_cmd_q[$];

  // Bookkeeping for the summary and for the stimulus quotas.
  int errors            = 0;
  int accepted_items    = 0;
  int ignored_items     = 0;
  int dropped_transfers = 0;
  int packets_checked   = 0;
  int finishes_ok       = 0;
  int finishes_nak      = 0;
  int finishes_stall    = 0;
  int holdoffs_done     = 0;

  // Idling knobs, changed by the stimulus as it goes.
  int       tx_gap_max   = 3;
  int       burst_left   = 0;
  rx_mode_t rx_mode      = RX_RANDOM;
  int       rx_stall_pct = 30;
  bit       hold_off_req = 1'b0;

  // Zero max packet size behaves as 1, anything above 64 as 64.
  function automatic logic [6:0] mps_eff();
    if (cfg_mps == 7'd0) return 7'd1;
    if (cfg_mps > uhts_pkg::MPS_MAX) return uhts_pkg::MPS_MAX;
    return cfg_mps;
  endfunction

  // A retry limit of zero still allows one attempt.
  function automatic logic [7:0] retry_eff();
    return (cfg_retry == 8'd0) ? 8'd1 : cfg_retry;
  endfunction

  function automatic logic [1:0] xfer_pid();
    if (seq_phase == uhts_pkg::PH_IN) return uhts_pkg::TOK_IN;
    return seq_setup ? uhts_pkg::TOK_SETUP : uhts_pkg::TOK_OUT;
  endfunction

  // Size the next packet; an IN packet that would run past the buffer end
  // restarts at the buffer base.
  function automatic void plan_packet();
    pkt_len = (bytes_left > mps_eff()) ? mps_eff() : bytes_left[6:0];
    if (seq_phase == uhts_pkg::PH_IN && int'(in_ptr) + int'(pkt_len) > int'(BUF_END))
      in_ptr = BUF_BASE;
    tries = 8'd1;
  endfunction

  function automatic void queue_packet();
    host_result_t r;
    r        = '0;
    r.kind   = uhts_pkg::RK_PACKET;
    r.pid    = xfer_pid();
    r.len    = pkt_len;
    r.addr   = (seq_phase == uhts_pkg::PH_IN) ? in_ptr : BUF_BASE;
    r.offset = xfer_total - bytes_left;
    r.tog    = (seq_phase == uhts_pkg::PH_IN) ? in_tog : out_tog;
    r.pre    = cfg_pre;
    host_cmd_q.push_back(r);
  endfunction

  function automatic void queue_finish(logic [1:0] st, logic [11:0] count);
    host_result_t r;
    r       = '0;
    r.kind  = uhts_pkg::RK_FINISH;
    r.pid   = xfer_pid();
    r.st    = st;
    r.count = count;
    host_cmd_q.push_back(r);
    seq_phase = uhts_pkg::PH_IDLE;
  endfunction

  // Advance the model by one accepted item.
  function automatic void step_sequencer(logic [1:0] act, logic [11:0] sz,
                                         logic [1:0] hs, logic [6:0] res);
    logic [6:0] got;
    if (act != uhts_pkg::ACT_HS) begin
      // a new start silently replaces a running transfer
      if (seq_phase != uhts_pkg::PH_IDLE) dropped_transfers++;
      seq_phase  = (act == uhts_pkg::ACT_IN) ? uhts_pkg::PH_IN : uhts_pkg::PH_OUT;
      seq_setup  = (act == uhts_pkg::ACT_SETUP);
      xfer_total = sz;
      bytes_left = sz;
      in_ptr     = BUF_BASE;
      plan_packet();
      queue_packet();
      return;
    end
    if (seq_phase == uhts_pkg::PH_IDLE) begin
      ignored_items++;
      return;
    end
    if (hs == uhts_pkg::HS_STALL) begin
      queue_finish(uhts_pkg::ST_STALL, '0);
      return;
    end
    if (hs != uhts_pkg::HS_ACK) begin
      // NAK, or the unused code which counts as NAK
      if (tries >= retry_eff()) begin
        queue_finish(uhts_pkg::ST_NAK, '0);
        return;
      end
      tries++;
      queue_packet();
      return;
    end
    if (seq_phase == uhts_pkg::PH_OUT) begin
      bytes_left -= 12'(pkt_len);
      out_tog = ~out_tog;
      if (bytes_left == '0) begin
        queue_finish(uhts_pkg::ST_OK, xfer_total);
        return;
      end
    end else begin
      // residual beyond the packet length means nothing arrived
      got        = (res > pkt_len) ? 7'd0 : pkt_len - res;
      bytes_left -= 12'(got);
      in_tog     = ~in_tog;
      in_ptr     = in_ptr + 8'(got);
      if (bytes_left == '0 || got != pkt_len) begin
        queue_finish(uhts_pkg::ST_OK, xfer_total - bytes_left);
        return;
      end
    end
    plan_packet();
    queue_packet();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the receiver's ready pattern and the checker.
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_hold  = 0;

  // Long hold-off is counted here, so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      rx_hold      = HOLD_OFF_CYCLES;
      holdoffs_done++;
      result_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  result_ready <= 1'b1;
        RX_RANDOM:  result_ready <= ($urandom_range(99) >= rx_stall_pct);
        default:    result_ready <= ((rx_cycle % 11) > 3);
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Sampled at the falling edge: a transfer seen here lands at the next rising edge.
  always @(negedge clk) begin : check_results
    host_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (host_cmd_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none actual kind %0d pid %0d",
                 $time, result_kind, packet_pid);
      end else begin
        want = host_cmd_q.pop_front();
        check_field("result_kind",    32'(want.kind),   32'(result_kind));
        check_field("packet_pid",     32'(want.pid),    32'(packet_pid));
        check_field("packet_length",  32'(want.len),    32'(packet_length));
        check_field("buffer_address", 32'(want.addr),   32'(buffer_address));
        check_field("data_offset",    32'(want.offset), 32'(data_offset));
        check_field("data_toggle",    32'(want.tog),    32'(data_toggle));
        check_field("preamble",       32'(want.pre),    32'(preamble));
        check_field("status",         32'(want.st),     32'(status));
        check_field("byte_count",     32'(want.count),  32'(byte_count));
        if (want.kind == uhts_pkg::RK_PACKET) packets_checked++;
        else if (want.st == uhts_pkg::ST_OK) finishes_ok++;
        else if (want.st == uhts_pkg::ST_NAK) finishes_nak++;
        else finishes_stall++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item side. All tasks enter and leave just after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item; the sender runs in bursts with random gaps in between.
  // Valid stays up across back-to-back items.
  task automatic send_item(input logic [1:0] act, input logic [11:0] sz,
                           input logic [1:0] hs, input logic [6:0] res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap        = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 1);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid     <= 1'b1;
    action         <= act;
    transfer_size  <= sz;
    handshake      <= hs;
    residual_count <= res;
    do @(negedge clk); while (!item_ready);
    step_sequencer(act, sz, hs, res);
    accepted_items++;
    @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic settle();
    item_valid <= 1'b0;
    while (host_cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands on this edge; go straight into the read setup
    case (idx)
      uhts_pkg::REG_DEV_ADDR:  cfg_dev_addr = value[6:0];
      uhts_pkg::REG_ENDPOINT:  cfg_endpoint = value[3:0];
      uhts_pkg::REG_MAX_PKT:   cfg_mps      = value[6:0];
      uhts_pkg::REG_RETRY_LIM: cfg_retry    = value[7:0];
      default:                 cfg_pre      = value[0];
    endcase
    case (idx)
      uhts_pkg::REG_DEV_ADDR:  stored = 32'(cfg_dev_addr);
      uhts_pkg::REG_ENDPOINT:  stored = 32'(cfg_endpoint);
      uhts_pkg::REG_MAX_PKT:   stored = 32'(cfg_mps);
      uhts_pkg::REG_RETRY_LIM: stored = 32'(cfg_retry);
      default:                 stored = 32'(cfg_pre);
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("register read-back", stored, readback);
  endtask

  task automatic configure(input logic [6:0] dev, input logic [3:0] ep, input logic [6:0] mps,
                           input logic [7:0] retry, input logic pre);
    write_register(uhts_pkg::REG_DEV_ADDR,  32'(dev));
    write_register(uhts_pkg::REG_ENDPOINT,  32'(ep));
    write_register(uhts_pkg::REG_MAX_PKT,   32'(mps));
    write_register(uhts_pkg::REG_RETRY_LIM, 32'(retry));
    write_register(uhts_pkg::REG_PREAMBLE,  32'(pre));
  endtask

  // One transfer with random content: mostly ACKs, some NAK retries, the odd
  // code, stalls, short IN packets and abandoned transfers.
  task automatic random_transfer();
    logic [1:0]  act;
    logic [11:0] sz;
    logic [1:0]  hs;
    logic [6:0]  res;
    bit          storm;
    int          steps;
    int          r;
    // reshuffle idling now and then so every mix shows up, including none
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0:       tx_gap_max = 0;
        1:       tx_gap_max = 3;
        default: tx_gap_max = 12;
      endcase
      rx_mode      = rx_mode_t'($urandom_range(2));
      rx_stall_pct = $urandom_range(70, 10);
    end
    // noise: a handshake with no transfer running
    if ($urandom_range(11) == 0)
      send_item(uhts_pkg::ACT_HS, 12'($urandom), 2'($urandom), 7'($urandom));
    act = 2'($urandom_range(2));
    r   = $urandom_range(15);
    if (r == 0) sz = 12'($urandom);
    else if (r == 1) sz = '0;
    else sz = 12'($urandom_range(int'(mps_eff()) * 5));
    send_item(act, sz, 2'($urandom), 7'($urandom));
    // a NAK storm runs the retry counter out, only worth it for small limits
    storm = (retry_eff() <= 8'd8) && ($urandom_range(7) == 0);
    steps = 0;
    while (seq_phase != uhts_pkg::PH_IDLE) begin
      if (steps >= 96 || $urandom_range(49) == 0) begin
        if ($urandom_range(1) != 0) return;  // abandoned; the next start replaces it
        hs = uhts_pkg::HS_STALL;
      end else if (storm) begin
        hs = ($urandom_range(1) != 0) ? uhts_pkg::HS_NAK : HS_ODD;
      end else begin
        r = $urandom_range(99);
        if (r < 80) hs = uhts_pkg::HS_ACK;
        else if (r < 91) hs = uhts_pkg::HS_NAK;
        else if (r < 95) hs = HS_ODD;
        else hs = uhts_pkg::HS_STALL;
      end
      if (seq_phase == uhts_pkg::PH_IN) begin
        r = $urandom_range(99);
        if (r < 85) res = '0;
        else if (r < 95) res = 7'($urandom_range(int'(pkt_len)));
        else res = 7'($urandom);
      end else begin
        res = 7'($urandom);
      end
      send_item(uhts_pkg::ACT_HS, 12'($urandom), hs, res);
      steps++;
    end
  endtask

  // One configuration setting, then random transfers until the quota of
  // items that did something is met; ends idle and drained.
  task automatic random_phase(input logic [6:0] mps, input logic [7:0] retry, input logic pre,
                              input int quota, input bit hold);
    int base;
    configure(7'($urandom), 4'($urandom), mps, retry, pre);
    if (hold) begin
      tx_gap_max   = 0;
      hold_off_req = 1'b1;
    end
    base = accepted_items - ignored_items;
    while (accepted_items - ignored_items - base < quota) random_transfer();
    if (seq_phase != uhts_pkg::PH_IDLE)
      send_item(uhts_pkg::ACT_HS, '0, uhts_pkg::HS_STALL, '0);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every register at both ends of its range, checked by read-back.
  task automatic test_register_access();
    configure(7'd127, 4'd15, 7'd127, 8'd255, 1'b1);
    configure(7'd0, 4'd0, 7'd0, 8'd0, 1'b0);
  endtask

  // Hand-picked sequences for each corner of the transfer rules.
  task automatic test_directed_transfers();
    configure(7'd5, 4'd2, 7'd8, 8'd2, 1'b1);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);  // idle: dropped
    send_item(uhts_pkg::ACT_OUT,   12'd0,    uhts_pkg::HS_ACK, 7'd0);  // one empty packet
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_SETUP, 12'd8,    uhts_pkg::HS_ACK, 7'd0);  // shares OUT toggle
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_OUT,   12'd20,   uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_NAK, 7'd0);  // retry same packet
    send_item(uhts_pkg::ACT_HS,    12'd0,    HS_ODD, 7'd0);            // as NAK: limit hit
    send_item(uhts_pkg::ACT_OUT,   12'd20,   uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);  // 8 + 8 + 4 done
    send_item(uhts_pkg::ACT_IN,    12'd20,   uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_ACK, 7'd3);  // short IN packet
    send_item(uhts_pkg::ACT_IN,    12'd4095, uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_IN,    12'd30,   uhts_pkg::HS_ACK, 7'd0);  // restart while busy
    send_item(uhts_pkg::ACT_HS,    12'd4095, uhts_pkg::HS_ACK, 7'd127); // residual too big
    send_item(uhts_pkg::ACT_OUT,   12'd4095, uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_STALL, 7'd0);
    settle();
    // full-size IN packets walk the buffer pointer past its end
    configure(7'd1, 4'd9, 7'd64, 8'd1, 1'b0);
    send_item(uhts_pkg::ACT_IN,    12'd320,  uhts_pkg::HS_ACK, 7'd0);
    repeat (4) send_item(uhts_pkg::ACT_HS, 12'd0, uhts_pkg::HS_ACK, 7'd0);
    send_item(uhts_pkg::ACT_HS,    12'd0,    uhts_pkg::HS_NAK, 7'd0);  // retry limit of one
    settle();
  endtask

  // Zero and oversized packet size, zero retry limit.
  task automatic test_clamped_settings();
    random_phase(7'd0,   8'd0, 1'b1, 150, 1'b0);
    random_phase(7'd127, 8'd2, 1'b0, 150, 1'b0);
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_receiver_holdoff();
    random_phase(7'd16, 8'd4, 1'b0, 200, 1'b1);
  endtask

  task automatic test_random_traffic();
    random_phase(7'd8,  8'd3,   1'b0, 400, 1'b0);
    random_phase(7'd64, 8'd255, 1'b1, 400, 1'b0);
    random_phase(7'd1,  8'd1,   1'b1, 250, 1'b0);
    random_phase(7'($urandom_range(63, 2)), 8'($urandom_range(16, 2)), 1'($urandom),
                 400, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_transfers();
    test_clamped_settings();
    test_receiver_holdoff();
    test_random_traffic();
    settle();
    $display("Run covered %0d items (%0d idle handshakes, %0d restarts) and %0d hold-offs",
             accepted_items, ignored_items, dropped_transfers, holdoffs_done);
    $display("Checked %0d packet commands and %0d/%0d/%0d ok/NAK/STALL finishes, %0d errors",
             packets_checked, finishes_ok, finishes_nak, finishes_stall, errors);
    if (errors == 0) begin
      $display("PASS usb_host_transfer_sequencer_unit");
    end else begin
      $display("FAIL usb_host_transfer_sequencer_unit");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", host_cmd_q.size());
    $display("FAIL usb_host_transfer_sequencer_unit");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/uhts_pkg.sv
rtl/usb_host_transfer_sequencer_unit.sv
bench/usb_host_transfer_sequencer_unit_tb.sv
